@@ rtl/rsz_pkg.sv @@
// Shared types and constants for the bilinear image resizer
`timescale 1ns / 1ps
package rsz_pkg;
	localparam int MAX_SRC_W  = 256;
	localparam int MAX_SRC_H  = 256;
	localparam int FRAC_BITS  = 8;
	localparam int COL_W      = $clog2(MAX_SRC_W);
	localparam int ROW_W      = $clog2(MAX_SRC_H);
	localparam int SIZE_W     = 9;
	localparam int DST_W      = 13;
	localparam int CRD_W      = 12;
	localparam int PIX_W      = 8;
	localparam int VAL_W      = 16;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;
	localparam int PROD_W     = CRD_W + 1 + SIZE_W;
	localparam int NUM_W      = PROD_W + FRAC_BITS;
	localparam int DEN_W      = DST_W + 1;
	localparam int Q_W        = FRAC_BITS + ((COL_W > ROW_W) ? COL_W : ROW_W);
	localparam int WGT_W      = FRAC_BITS + 1;
	localparam int WP_W       = 2 * FRAC_BITS + 1;
	localparam int MUL_W      = WP_W + PIX_W;
	localparam int ACC_W      = MUL_W + 2;
	localparam int BANK_AW    = (COL_W - 1) + (ROW_W - 1);
	localparam int BANK_DEPTH = 1 << BANK_AW;
	localparam int LATENCY    = 2 + Q_W + 4;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_COMPUTE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_SRC_W = 2'd0,
		REG_SRC_H = 2'd1,
		REG_DST_W = 2'd2,
		REG_DST_H = 2'd3
	} reg_idx_t;

	typedef struct packed {
		op_t              op;
		logic [PIX_W-1:0] pixel;
		logic [COL_W-1:0] src_col;
		logic [ROW_W-1:0] src_row;
		logic [CRD_W-1:0] dst_col;
		logic [CRD_W-1:0] dst_row;
	} item_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [CRD_W-1:0] out_col;
		logic [CRD_W-1:0] out_row;
	} result_t;

	// item travelling beside the datapath
	typedef struct packed {
		logic  valid;
		item_t item;
	} side_t;

	// one axis after mapping: low neighbour and its two weights
	typedef struct packed {
		logic [COL_W-1:0] lo;
		logic [WGT_W-1:0] wlo;
		logic [WGT_W-1:0] whi;
	} axis_t;
endpackage

@@ rtl/bilinear_image_resize_unit.sv @@
// Top level of the bilinear image resizer: config registers, pipeline, image banks
// Each compute item taken gives one result, in the order taken.
// Throughput: one item per clock; busy stays low. Loads give no result.
// The sixteen-stage dividers, one per axis, set most of the latency.
// Reset clears the valid bits and sets all size registers to 256; image
// content is undefined until loaded. The receiver cannot stall the output.
`timescale 1ns / 1ps
module bilinear_image_resize_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rsz_pkg::ADDR_W-1:0]  paddr,
	input  logic [rsz_pkg::DATA_W-1:0]  pwdata,
	output logic [rsz_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        start,
	output logic                        busy,
	input  rsz_pkg::item_t              item,
	output logic                        done,
	output rsz_pkg::result_t            result
);
	import rsz_pkg::*;

	logic [SIZE_W-1:0] src_w_q, src_h_q, w_eff, h_eff;
	logic [DST_W-1:0]  dst_w_q, dst_h_q, nw_eff, nh_eff;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SIZE_W'(256);
			src_h_q <= SIZE_W'(256);
			dst_w_q <= DST_W'(256);
			dst_h_q <= DST_W'(256);
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_SRC_W: src_w_q <= pwdata[SIZE_W-1:0];
				REG_SRC_H: src_h_q <= pwdata[SIZE_W-1:0];
				REG_DST_W: dst_w_q <= pwdata[DST_W-1:0];
				REG_DST_H: dst_h_q <= pwdata[DST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_SRC_W: prdata = DATA_W'(src_w_q);
			REG_SRC_H: prdata = DATA_W'(src_h_q);
			REG_DST_W: prdata = DATA_W'(dst_w_q);
			REG_DST_H: prdata = DATA_W'(dst_h_q);
			default:   prdata = '0;
		endcase
	end

	// the user must change sizes only while idle (the block does not enforce it); every stage reads them directly
	always_comb begin
		w_eff = (src_w_q < SIZE_W'(2)) ? SIZE_W'(2) :
			(src_w_q > SIZE_W'(MAX_SRC_W)) ? SIZE_W'(MAX_SRC_W) : src_w_q;
		h_eff = (src_h_q < SIZE_W'(2)) ? SIZE_W'(2) :
			(src_h_q > SIZE_W'(MAX_SRC_H)) ? SIZE_W'(MAX_SRC_H) : src_h_q;
		nw_eff = (dst_w_q == '0) ? DST_W'(1) : dst_w_q;
		nh_eff = (dst_h_q == '0) ? DST_W'(1) : dst_h_q;
	end

	// stage 1: (2x+1)*n
	side_t             side_s1;
	logic [PROD_W-1:0] prod_x_s1, prod_y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1.valid <= start && !busy;
			side_s1.item  <= item;
		end
	end

	always_ff @(posedge clk) begin
		prod_x_s1 <= PROD_W'(PROD_W'({item.dst_col, 1'b1}) * PROD_W'(w_eff));
		prod_y_s1 <= PROD_W'(PROD_W'({item.dst_row, 1'b1}) * PROD_W'(h_eff));
	end

	// stage 2: numerator of the half-pixel mapping, floored at zero
	side_t            side_s2;
	logic [NUM_W-1:0] num_x_s2, num_y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else begin
			side_s2 <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		num_x_s2 <= (prod_x_s1 > PROD_W'(nw_eff)) ?
			NUM_W'({PROD_W'(prod_x_s1 - PROD_W'(nw_eff)), {FRAC_BITS{1'b0}}}) : '0;
		num_y_s2 <= (prod_y_s1 > PROD_W'(nh_eff)) ?
			NUM_W'({PROD_W'(prod_y_s1 - PROD_W'(nh_eff)), {FRAC_BITS{1'b0}}}) : '0;
	end

	// divider stages, item alongside
	logic [Q_W-1:0] q_x, q_y;
	logic           ovf_x, ovf_y;
	side_t          side_d [0:Q_W-1];

	rsz_div u_div_x (
		.clk  (clk),
		.num  (num_x_s2),
		.den  ({nw_eff, 1'b0}),
		.quot (q_x),
		.ovf  (ovf_x)
	);

	rsz_div u_div_y (
		.clk  (clk),
		.num  (num_y_s2),
		.den  ({nh_eff, 1'b0}),
		.quot (q_y),
		.ovf  (ovf_y)
	);

	for (genvar k = 0; k < Q_W; k++) begin : g_side
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					side_d[k] <= '0;
				end else begin
					side_d[k] <= side_s2;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					side_d[k] <= '0;
				end else begin
					side_d[k] <= side_d[k-1];
				end
			end
		end
	end

	// stage 3: neighbours and weights
	side_t side_s3;
	axis_t ax_s3, ay_s3;

	rsz_map u_map_x (
		.clk     (clk),
		.quot    (q_x),
		.ovf     (ovf_x),
		.n       (w_eff),
		.axis_s3 (ax_s3)
	);

	rsz_map u_map_y (
		.clk     (clk),
		.quot    (q_y),
		.ovf     (ovf_y),
		.n       (h_eff),
		.axis_s3 (ay_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else begin
			side_s3 <= side_d[Q_W-1];
		end
	end

	// stage 4: bank access (loads write here, in order) and weight products
	logic [PIX_W-1:0] rdata_s4 [0:3];
	logic [WP_W-1:0]  wp_s4    [0:3];
	logic             xpar_s4, ypar_s4;
	side_t            side_s4;
	logic             load_s3;

	assign load_s3 = side_s3.valid && side_s3.item.op == OP_LOAD;

	// bank index is {row parity, column parity}; xl and xl+1 never share a bank
	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [COL_W-1:0] col_sel;
		logic [ROW_W-1:0] row_sel;
		logic             we;
		assign col_sel = (ax_s3.lo[0] == b[0]) ? ax_s3.lo : COL_W'(ax_s3.lo + COL_W'(1));
		assign row_sel = (ay_s3.lo[0] == b[1]) ? ay_s3.lo : ROW_W'(ay_s3.lo + ROW_W'(1));
		assign we = load_s3 && side_s3.item.src_col[0] == b[0]
			&& side_s3.item.src_row[0] == b[1];
		rsz_bank u_bank (
			.clk   (clk),
			.we    (we),
			.waddr ({side_s3.item.src_row[ROW_W-1:1], side_s3.item.src_col[COL_W-1:1]}),
			.wdata (side_s3.item.pixel),
			.raddr ({row_sel[ROW_W-1:1], col_sel[COL_W-1:1]}),
			.rdata (rdata_s4[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
		end else begin
			side_s4.valid <= side_s3.valid && side_s3.item.op == OP_COMPUTE;
			side_s4.item  <= side_s3.item;
		end
	end

	always_ff @(posedge clk) begin
		xpar_s4  <= ax_s3.lo[0];
		ypar_s4  <= ay_s3.lo[0];
		wp_s4[0] <= WP_W'(WP_W'(ax_s3.wlo) * WP_W'(ay_s3.wlo));
		wp_s4[1] <= WP_W'(WP_W'(ax_s3.wlo) * WP_W'(ay_s3.whi));
		wp_s4[2] <= WP_W'(WP_W'(ax_s3.whi) * WP_W'(ay_s3.wlo));
		wp_s4[3] <= WP_W'(WP_W'(ax_s3.whi) * WP_W'(ay_s3.whi));
	end

	// stage 5: pixel times weight; order p00, p10 (yh), p01 (xh), p11
	logic [PIX_W-1:0] pix [0:3];
	logic [MUL_W-1:0] m_s5 [0:3];
	side_t            side_s5;

	always_comb begin
		pix[0] = rdata_s4[{ypar_s4, xpar_s4}];
		pix[1] = rdata_s4[{~ypar_s4, xpar_s4}];
		pix[2] = rdata_s4[{ypar_s4, ~xpar_s4}];
		pix[3] = rdata_s4[{~ypar_s4, ~xpar_s4}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s5 <= '0;
		end else begin
			side_s5 <= side_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			m_s5[i] <= MUL_W'(MUL_W'(pix[i]) * MUL_W'(wp_s4[i]));
		end
	end

	// stage 6: sum and truncate to Q8.8
	logic [ACC_W-1:0] acc;
	logic             done_s6;
	result_t          result_s6;

	assign acc = ACC_W'(m_s5[0]) + ACC_W'(m_s5[1]) + ACC_W'(m_s5[2]) + ACC_W'(m_s5[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s6 <= 1'b0;
		end else begin
			done_s6 <= side_s5.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_s6.value   <= VAL_W'(acc >> (2 * FRAC_BITS - 8));
		result_s6.out_col <= side_s5.item.dst_col;
		result_s6.out_row <= side_s5.item.dst_row;
	end

	assign done   = done_s6;
	assign result = result_s6;
endmodule

@@ rtl/rsz_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow flag
`timescale 1ns / 1ps
module rsz_div (
	input  logic                      clk,
	input  logic [rsz_pkg::NUM_W-1:0] num,
	input  logic [rsz_pkg::DEN_W-1:0] den,
	output logic [rsz_pkg::Q_W-1:0]   quot,
	output logic                      ovf
);
	import rsz_pkg::*;

	logic [DEN_W-1:0] rem_s [1:Q_W];
	logic [Q_W-1:0]   lo_s  [1:Q_W];
	logic [Q_W-1:0]   q_s   [1:Q_W];
	logic             ovf_s [1:Q_W];
	logic             ovf_in;
	logic [DEN_W-1:0] rem_in;

	// quotient would not fit in Q_W bits
	assign ovf_in = DEN_W'(num[NUM_W-1:Q_W]) >= den;
	assign rem_in = ovf_in ? '0 : DEN_W'(num[NUM_W-1:Q_W]);

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic [DEN_W-1:0] rem_p;
		logic [Q_W-1:0]   lo_p;
		logic [Q_W-1:0]   q_p;
		logic             ovf_p;
		logic [DEN_W:0]   trial;
		logic             ge;
		if (k == 0) begin : g_first
			assign rem_p = rem_in;
			assign lo_p  = num[Q_W-1:0];
			assign q_p   = '0;
			assign ovf_p = ovf_in;
		end else begin : g_next
			assign rem_p = rem_s[k];
			assign lo_p  = lo_s[k];
			assign q_p   = q_s[k];
			assign ovf_p = ovf_s[k];
		end
		assign trial = {rem_p, lo_p[Q_W-1]};
		assign ge    = trial >= {1'b0, den};
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
			lo_s[k+1]  <= {lo_p[Q_W-2:0], 1'b0};
			q_s[k+1]   <= {q_p[Q_W-2:0], ge};
			ovf_s[k+1] <= ovf_p;
		end
	end

	assign quot = q_s[Q_W];
	assign ovf  = ovf_s[Q_W];
endmodule

@@ rtl/rsz_map.sv @@
// Clamp of the source position and choice of neighbour and weights, one axis
`timescale 1ns / 1ps
module rsz_map (
	input  logic                       clk,
	input  logic [rsz_pkg::Q_W-1:0]    quot,
	input  logic                       ovf,
	input  logic [rsz_pkg::SIZE_W-1:0] n,
	output rsz_pkg::axis_t             axis_s3
);
	import rsz_pkg::*;

	logic [COL_W-1:0] nm1;
	logic [Q_W-1:0]   tmax;
	logic [Q_W-1:0]   t;
	logic [COL_W-1:0] lraw;
	logic [COL_W-1:0] lo;
	logic [WGT_W-1:0] whi;

	always_comb begin
		nm1  = COL_W'(n - SIZE_W'(1));
		tmax = Q_W'({nm1, {FRAC_BITS{1'b0}}});
		t    = (ovf || quot > tmax) ? tmax : quot;
		lraw = COL_W'(t >> FRAC_BITS);
		// on the last pixel step back one so the weight sits on the edge
		lo   = (lraw == nm1) ? COL_W'(nm1 - COL_W'(1)) : lraw;
		whi  = WGT_W'(t - Q_W'({lo, {FRAC_BITS{1'b0}}}));
	end

	always_ff @(posedge clk) begin
		axis_s3.lo  <= lo;
		axis_s3.whi <= whi;
		axis_s3.wlo <= WGT_W'(WGT_W'(1 << FRAC_BITS) - whi);
	end
endmodule

@@ rtl/rsz_bank.sv @@
// One bank of the source image store, registered read
`timescale 1ns / 1ps
module rsz_bank (
	input  logic                        clk,
	input  logic                        we,
	input  logic [rsz_pkg::BANK_AW-1:0] waddr,
	input  logic [rsz_pkg::PIX_W-1:0]   wdata,
	input  logic [rsz_pkg::BANK_AW-1:0] raddr,
	output logic [rsz_pkg::PIX_W-1:0]   rdata
);
	import rsz_pkg::*;

	logic [PIX_W-1:0] mem [0:BANK_DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/rsz_chk.sv @@
// Port-level checks for the bilinear image resizer, bound to the top level
`timescale 1ns / 1ps
module rsz_chk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rsz_pkg::ADDR_W-1:0] paddr,
	input  logic [rsz_pkg::DATA_W-1:0] pwdata,
	input  logic [rsz_pkg::DATA_W-1:0] prdata,
	input  logic                       pready,
	input  logic                       start,
	input  logic                       busy,
	input  rsz_pkg::item_t             item,
	input  logic                       done,
	input  rsz_pkg::result_t           result
);
	import rsz_pkg::*;

	localparam int AGE_W = $clog2(LATENCY + 1);

	logic [AGE_W-1:0] age_q;
	logic             settled;
	logic             comp_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (age_q != AGE_W'(LATENCY)) begin
			age_q <= AGE_W'(age_q + AGE_W'(1));
		end
	end

	assign settled = age_q == AGE_W'(LATENCY);
	assign comp_in = start && !busy && item.op == OP_COMPUTE;

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		settled && done |-> $past(comp_in, LATENCY))
		else $error("result without a compute transfer");

	a_result_tag: assert property (@(posedge clk) disable iff (!arst_n)
		settled && comp_in |-> ##LATENCY (done
			&& result.out_col == $past(item.dst_col, LATENCY)
			&& result.out_row == $past(item.dst_row, LATENCY)))
		else $error("compute transfer gave no matching result");

	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[3:2] == REG_SRC_W
		|=> (paddr[3:2] != REG_SRC_W || prdata[SIZE_W-1:0] == $past(pwdata[SIZE_W-1:0])))
		else $error("source width readback mismatch");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");
endmodule

bind bilinear_image_resize_unit rsz_chk u_rsz_chk (.*);

@@ dv/rsz_checker.sv @@
// Checker for the bilinear resizer: image and size shadow, result prediction and compare
`timescale 1ns / 1ps
module rsz_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rsz_pkg::ADDR_W-1:0] paddr,
	input  logic [rsz_pkg::DATA_W-1:0] pwdata,
	input  logic                       pready,
	input  logic                       start,
	input  logic                       busy,
	input  rsz_pkg::item_t             item,
	input  logic                       done,
	input  rsz_pkg::result_t           result,
	output int                         fail_count,
	output int                         pending
);
	import rsz_pkg::*;

	// known is low when a neighbour was never loaded: only the tags are compared
	typedef struct packed {
		logic    known;
		result_t r;
	} exp_t;

	logic [7:0] image_mem [0:MAX_SRC_W*MAX_SRC_H-1];
	bit written [0:MAX_SRC_W*MAX_SRC_H-1];
	logic [8:0] sw, sh;
	logic [12:0] dw, dh;
	exp_t expected_pixels[$];

	// map one axis: low/high neighbour and their Q8 weights
	function automatic void map_axis(input longint crd, input longint ns, input longint nd,
		output longint lo, output longint hi, output longint wlo, output longint whi);
		longint one, plus, minus, t, tmax;
		one = 1 << FRAC_BITS;
		plus = (2 * crd + 1) * ns * one;
		minus = nd * one;
		t = 0;
		tmax = (ns - 1) * one;
		if (plus > minus)
			t = (plus - minus) / (2 * nd);
		if (t > tmax)
			t = tmax;
		lo = t >> FRAC_BITS;
		hi = (lo + 1 < ns - 1) ? lo + 1 : ns - 1;
		if (lo == hi)
			lo = lo - 1;
		whi = t - lo * one;
		wlo = hi * one - t;
	endfunction

	function automatic exp_t resize_pixel(input item_t it);
		longint w, h, nw, nh, xl, xh, wxl, wxh, yl, yh, wyl, wyh, acc;
		exp_t e;
		w = (sw < 2) ? 2 : (sw > MAX_SRC_W) ? MAX_SRC_W : sw;
		h = (sh < 2) ? 2 : (sh > MAX_SRC_H) ? MAX_SRC_H : sh;
		nw = (dw == 0) ? 1 : dw;
		nh = (dh == 0) ? 1 : dh;
		map_axis(it.dst_col, w, nw, xl, xh, wxl, wxh);
		map_axis(it.dst_row, h, nh, yl, yh, wyl, wyh);
		acc = image_mem[yl*MAX_SRC_W+xl] * wxl * wyl + image_mem[yh*MAX_SRC_W+xl] * wxl * wyh
			+ image_mem[yl*MAX_SRC_W+xh] * wxh * wyl + image_mem[yh*MAX_SRC_W+xh] * wxh * wyh;
		acc = acc >> (2 * FRAC_BITS - 8);
		e.known = written[yl*MAX_SRC_W+xl] && written[yh*MAX_SRC_W+xl]
			&& written[yl*MAX_SRC_W+xh] && written[yh*MAX_SRC_W+xh];
		e.r.value = acc[15:0];
		e.r.out_col = it.dst_col;
		e.r.out_row = it.dst_row;
		return e;
	endfunction

	assign pending = expected_pixels.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw <= 256; sh <= 256; dw <= 256; dh <= 256;
			fail_count <= 0;
			expected_pixels.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_SRC_W: sw <= pwdata[8:0];
					REG_SRC_H: sh <= pwdata[8:0];
					REG_DST_W: dw <= pwdata[12:0];
					REG_DST_H: dh <= pwdata[12:0];
					default: ;
				endcase
			end
			if (done) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, result);
					fail_count <= fail_count + 1;
				end else begin
					exp_t e;
					e = expected_pixels.pop_front();
					if ((e.known && e.r.value !== result.value)
						|| e.r.out_col !== result.out_col
						|| e.r.out_row !== result.out_row) begin
						$display({"%0t: mismatch expected value %h col %0d row %0d,",
							" actual value %h col %0d row %0d"},
							$time, e.r.value, e.r.out_col, e.r.out_row,
							result.value, result.out_col, result.out_row);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) begin
				if (item.op == OP_LOAD) begin
					image_mem[{item.src_row, item.src_col}] = item.pixel;
					written[{item.src_row, item.src_col}] = 1'b1;
				end else begin
					expected_pixels.push_back(resize_pixel(item));
				end
			end
		end
	end
endmodule

@@ dv/tb_bilinear_image_resize_unit.sv @@
// Testbench top for the bilinear resizer: stimulus, size settings and verdict
`timescale 1ns / 1ps
module tb_bilinear_image_resize_unit;
	import rsz_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = 0;
	logic [DATA_W-1:0] pwdata = 0;
	logic [DATA_W-1:0] prdata;
	logic pready, start = 0, busy, done;
	item_t item = '0;
	result_t result;
	int fail_count, pending;
	int idle_pct;

	always #1 clk = ~clk;

	bilinear_image_resize_unit dut (.*);
	rsz_checker chk (.*);

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// one item transfer, with random sender gaps
	task automatic send_item(input item_t it);
		while ($urandom_range(99) < idle_pct) begin
			@(posedge clk);
			start <= 0;
		end
		@(posedge clk);
		start <= 1; item <= it;
		while (busy) @(posedge clk);
	endtask

	task automatic drain;
		@(posedge clk);
		start <= 0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic load_px(input int c, input int r, input int v);
		item_t it;
		it = '0;
		it.op = OP_LOAD;
		it.src_col = COL_W'(c);
		it.src_row = ROW_W'(r);
		it.pixel = PIX_W'(v);
		send_item(it);
	endtask

	task automatic compute_px(input int c, input int r);
		item_t it;
		it = item_t'($urandom());
		it.op = OP_COMPUTE;
		it.dst_col = CRD_W'(c);
		it.dst_row = CRD_W'(r);
		send_item(it);
	endtask

	// fill the top-left 16x16 corner; small source sizes then read only written pixels
	task automatic fill_image;
		idle_pct = 0;
		for (int r = 0; r < 16; r++)
			for (int c = 0; c < 16; c++)
				load_px(c, r, (r == 0 && c < 2) ? 255 * c : $urandom_range(255));
	endtask

	task automatic set_sizes(input int a, input int b, input int c, input int d);
		drain();
		write_reg(REG_SRC_W, a);
		write_reg(REG_SRC_H, b);
		write_reg(REG_DST_W, c);
		write_reg(REG_DST_H, d);
	endtask

	initial begin
		int phase;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		fill_image();
		// directed: corners, far coordinates, odd sizes
		idle_pct = 0;
		compute_px(0, 0); compute_px(255, 255); compute_px(4095, 4095); compute_px(0, 4095);
		set_sizes(2, 2, 1, 1);
		compute_px(0, 0); compute_px(4095, 0); compute_px(1, 1);
		set_sizes(0, 511, 0, 8191);
		compute_px(0, 0); compute_px(4095, 4095); compute_px(7, 3000);
		set_sizes(256, 256, 4096, 4096);
		compute_px(0, 0); compute_px(4095, 4095); compute_px(2048, 17);
		set_sizes(3, 300, 5, 2);
		compute_px(2, 1); compute_px(4, 0);
		load_px(0, 0, 0); load_px(255, 255, 255); compute_px(0, 0); compute_px(300, 300);
		drain();
		// random phases over several size settings and idling levels
		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: idle_pct = 0;
				1: idle_pct = 85;
				2: idle_pct = 0;
				default: idle_pct = 23;
			endcase
			set_sizes((phase == 7) ? $urandom_range(511) : $urandom_range(16),
				(phase == 7) ? $urandom_range(511) : $urandom_range(16),
				$urandom_range(8191), $urandom_range(8191));
			for (int i = 0; i < 64; i++) begin
				if ($urandom_range(9) < 2)
					load_px($urandom_range(15), $urandom_range(15), $urandom_range(255));
				else if ($urandom_range(3) == 0)
					compute_px($urandom_range(4095), $urandom_range(4095));
				else
					compute_px($urandom_range(300), $urandom_range(300));
			end
		end
		drain();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule

@@ files.f @@
rtl/rsz_pkg.sv
rtl/rsz_div.sv
rtl/rsz_map.sv
rtl/rsz_bank.sv
rtl/bilinear_image_resize_unit.sv
rtl/rsz_chk.sv
dv/rsz_checker.sv
dv/tb_bilinear_image_resize_unit.sv
